### hw/rtl/urm_pkg.sv
// Shared constants and types for the ultrasonic range meter.
`default_nettype none

package urm_pkg;

   // Field and register widths
   localparam int CountBits     = 16;
   localparam int HalfWidth     = 8;
   localparam int EdgeWidth     = 4;
   localparam int ScaleWidth    = 16;
   localparam int DistWidth     = 8;
   localparam int ProductWidth  = CountBits + ScaleWidth;

   // Configuration port
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 16;
   localparam logic [CsrIndexWidth-1:0] CsrHalfPeriod = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBurstEdges = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrScale      = 2'd2;

   // Register reset values
   localparam logic [HalfWidth-1:0]  HalfPeriodReset = 8'd12;
   localparam logic [EdgeWidth-1:0]  BurstEdgesReset = 4'd10;
   localparam logic [ScaleWidth-1:0] ScaleReset      = 16'd1114;

   localparam logic [DistWidth-1:0]  DistMax = 8'hFF;

   // Result queue
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int OccWidth      = $clog2(QueueDepth + 1);

   typedef enum logic [2:0] {
      PHASE_IDLE   = 3'b001,
      PHASE_BURST  = 3'b010,
      PHASE_LISTEN = 3'b100
   } phase_type;

   // One processed tick, before distance scaling
   typedef struct packed {
      logic                 tx_level;
      logic                 busy;
      logic                 done;
      logic                 timed_out;
      logic [CountBits-1:0] count;
   } tick_type;

   // One result item
   typedef struct packed {
      logic                 tx_level;
      logic                 busy;
      logic                 done;
      logic [DistWidth-1:0] distance;
      logic                 timed_out;
   } result_type;

endpackage

`default_nettype wire

### hw/rtl/urm_phase.sv
// Burst and listen sequencer with the registered tick stage.
`default_nettype none

module urm_phase (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic                           start_req,
   input  wire logic                           echo_level,
   input  wire logic [urm_pkg::HalfWidth-1:0]  half_period,
   input  wire logic [urm_pkg::EdgeWidth-1:0]  burst_edges,
   output urm_pkg::tick_type                   tick,
   output logic                                tick_valid
);

   urm_pkg::phase_type                phase_ff, phase_in;
   logic [urm_pkg::CountBits-1:0]     count_ff, count_in, count_inc;
   logic [urm_pkg::EdgeWidth-1:0]     edges_ff, edges_in, edges_dec;
   logic                              tx_ff, tx_in;
   logic [urm_pkg::HalfWidth-1:0]     half_eff;
   urm_pkg::tick_type                 tick_ff, tick_in;
   logic                              tick_valid_ff;

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      edges_in  = edges_ff;
      tx_in     = tx_ff;
      count_inc = count_ff + 1'b1;
      edges_dec = edges_ff - 1'b1;
      half_eff  = (half_period == '0) ? urm_pkg::HalfWidth'(1) : half_period;
      tick_in   = '0;

      unique case (phase_ff)
         urm_pkg::PHASE_IDLE: begin
            if (start_req) begin
               tx_in    = 1'b0;
               count_in = '0;
               edges_in = burst_edges;
               phase_in = (burst_edges == '0) ? urm_pkg::PHASE_LISTEN
                                              : urm_pkg::PHASE_BURST;
            end
         end
         urm_pkg::PHASE_BURST: begin
            count_in = count_inc;
            if (count_inc >= urm_pkg::CountBits'(half_eff)) begin
               tx_in    = ~tx_ff;
               count_in = '0;
               edges_in = edges_dec;
               if (edges_dec == '0) begin
                  phase_in = urm_pkg::PHASE_LISTEN;
               end
            end
         end
         urm_pkg::PHASE_LISTEN: begin
            if (!echo_level) begin
               // echo seen: report the current count
               tick_in.done  = 1'b1;
               tick_in.count = count_ff;
               phase_in      = urm_pkg::PHASE_IDLE;
            end else begin
               count_in = count_inc;
               if (count_inc == '0) begin
                  tick_in.done      = 1'b1;
                  tick_in.timed_out = 1'b1;
                  phase_in          = urm_pkg::PHASE_IDLE;
               end
            end
         end
         default: begin
            phase_in = urm_pkg::PHASE_IDLE;
         end
      endcase

      tick_in.tx_level = tx_in;
      tick_in.busy     = (phase_in != urm_pkg::PHASE_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= urm_pkg::PHASE_IDLE;
         count_ff      <= '0;
         edges_ff      <= '0;
         tx_ff         <= 1'b0;
         tick_valid_ff <= 1'b0;
      end else begin
         tick_valid_ff <= accept;
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            edges_ff <= edges_in;
            tx_ff    <= tx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tick_ff <= tick_in;
      end
   end

   assign tick       = tick_ff;
   assign tick_valid = tick_valid_ff;

endmodule

`default_nettype wire

### hw/rtl/urm_result.sv
// Distance scaling and the result item queue.
`default_nettype none

module urm_result (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            tick_valid,
   input  wire urm_pkg::tick_type               tick,
   input  wire logic [urm_pkg::ScaleWidth-1:0]  scale,
   input  wire logic                            deliver,
   output urm_pkg::result_type                  result,
   output logic                                 result_valid
);

   logic [urm_pkg::ProductWidth-1:0]   product;
   logic [urm_pkg::CountBits-1:0]      whole_cm;
   urm_pkg::result_type                entry_in;

   urm_pkg::result_type                queue_ff [urm_pkg::QueueDepth];
   logic [urm_pkg::QueuePtrWidth-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [urm_pkg::OccWidth-1:0]       fill_ff, fill_in;

   always_comb begin
      product  = urm_pkg::ProductWidth'(tick.count) * urm_pkg::ProductWidth'(scale);
      whole_cm = product[urm_pkg::ProductWidth-1:urm_pkg::ScaleWidth];

      entry_in.tx_level  = tick.tx_level;
      entry_in.busy      = tick.busy;
      entry_in.done      = tick.done;
      entry_in.timed_out = tick.timed_out;
      // saturate at the top of the distance field
      entry_in.distance  = (whole_cm > urm_pkg::CountBits'(urm_pkg::DistMax))
                           ? urm_pkg::DistMax : whole_cm[urm_pkg::DistWidth-1:0];

      fill_in = fill_ff + urm_pkg::OccWidth'(tick_valid) - urm_pkg::OccWidth'(deliver);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (tick_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (deliver) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tick_valid) begin
         queue_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign result       = queue_ff[rd_ptr_ff];
   assign result_valid = (fill_ff != '0);

endmodule

`default_nettype wire

### hw/rtl/ultrasonic_range_meter.sv
// Top level of the ultrasonic range meter.
//
// Each req_ item is one microsecond tick carrying a start request and the
// receiver echo level. A start while idle drives the transmit pin low and
// runs a burst of burst_edges toggles, one every half_period_ticks ticks,
// then times the echo with a COUNT_BITS tick counter. Every tick yields one
// rsp_ item: pin level, busy, done, distance in cm (saturated at 255) and a
// timeout flag set when the counter wraps before the echo arrives.
//
// The sequencer updates its state in the accepting cycle and registers the
// tick; the scaling multiplier sits in the following one, and the queue
// registers the result that is offered on rsp_. Throughput is one item per
// cycle while req_stall is low.
// Results wait in a four-entry queue. req_stall rises only when four items
// are in flight, so input keeps flowing while a result waits for the
// receiver; a stalled result holds steady until taken.
// Reset (synchronous) returns the sequencer to idle with the pin low, empties
// the queue and restores the registers to 12, 10 and 1114.
// csr_ writes land at once; index 3 is ignored.
`default_nettype none

module ultrasonic_range_meter (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_start_req,
   input  wire logic                               req_echo_level,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_tx_level,
   output logic                                    rsp_busy_res,
   output logic                                    rsp_done_res,
   output logic [urm_pkg::DistWidth-1:0]           rsp_distance_cm,
   output logic                                    rsp_timed_out,

   input  wire logic                               csr_write_enable,
   input  wire logic [urm_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [urm_pkg::CsrDataWidth-1:0]   csr_write_data
);

   logic [urm_pkg::HalfWidth-1:0]   half_period_ff;
   logic [urm_pkg::EdgeWidth-1:0]   burst_edges_ff;
   logic [urm_pkg::ScaleWidth-1:0]  scale_ff;

   logic [urm_pkg::OccWidth-1:0]    in_flight_ff, in_flight_in;
   logic                            accept;
   logic                            deliver;

   urm_pkg::tick_type               tick;
   logic                            tick_valid;
   urm_pkg::result_type             result;

   // Configuration registers: write straight through on enable
   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= urm_pkg::HalfPeriodReset;
         burst_edges_ff <= urm_pkg::BurstEdgesReset;
         scale_ff       <= urm_pkg::ScaleReset;
      end else if (csr_write_enable) begin
         if (csr_index == urm_pkg::CsrHalfPeriod) begin
            half_period_ff <= csr_write_data[urm_pkg::HalfWidth-1:0];
         end
         if (csr_index == urm_pkg::CsrBurstEdges) begin
            burst_edges_ff <= csr_write_data[urm_pkg::EdgeWidth-1:0];
         end
         if (csr_index == urm_pkg::CsrScale) begin
            scale_ff <= csr_write_data[urm_pkg::ScaleWidth-1:0];
         end
      end
   end

   // Count items accepted but not yet delivered; hold input once the queue
   // could be filled by what is already in flight.
   assign req_stall    = (in_flight_ff == urm_pkg::OccWidth'(urm_pkg::QueueDepth));
   assign accept       = req_valid & ~req_stall;
   assign deliver      = rsp_valid & ~rsp_stall;
   assign in_flight_in = in_flight_ff + urm_pkg::OccWidth'(accept)
                                      - urm_pkg::OccWidth'(deliver);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   urm_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .start_req   (req_start_req),
      .echo_level  (req_echo_level),
      .half_period (half_period_ff),
      .burst_edges (burst_edges_ff),
      .tick        (tick),
      .tick_valid  (tick_valid)
   );

   urm_result u_result (
      .clock        (clock),
      .reset        (reset),
      .tick_valid   (tick_valid),
      .tick         (tick),
      .scale        (scale_ff),
      .deliver      (deliver),
      .result       (result),
      .result_valid (rsp_valid)
   );

   assign rsp_tx_level    = result.tx_level;
   assign rsp_busy_res    = result.busy;
   assign rsp_done_res    = result.done;
   assign rsp_distance_cm = result.distance;
   assign rsp_timed_out   = result.timed_out;

endmodule

`default_nettype wire
